### sv/tids_pkg.sv
// Shared types and constants for the transparent item depth sorter.
// Used by tids_key, tids_cell and transparent_item_depth_sorter; no dependencies.
package tids_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int COORD_W      = 24;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int SQ_W         = 2 * DIFF_W;
   localparam int KEY_W        = 52;
   localparam int TYPE_W       = 4;
   localparam int HANDLE_W     = 32;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_POP   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] REG_VIEW_X = 2'd0;
   localparam logic [1:0] REG_VIEW_Y = 2'd1;
   localparam logic [1:0] REG_VIEW_Z = 2'd2;

   localparam logic [TYPE_W-1:0] NULL_TYPE = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_INS
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [TYPE_W-1:0]   item_type;
      logic [HANDLE_W-1:0] handle;
      logic [HANDLE_W-1:0] owner;
   } entry_type;

   typedef struct packed {
      logic ins;
      logic pop;
   } cell_ctl_type;

endpackage

### sv/transparent_item_depth_sorter.sv
// Top level of the transparent item depth sorter: APB view registers, control FSM,
// key pipeline and a chain of sorting cells. Depends on tids_pkg, tids_key, tids_cell.
//
//   channel   ports              handshake
//   request   start, req_*       taken when start && !busy
//   result    rsp_*              rsp_valid for one cycle, no backpressure
//   config    psel..prdata       APB, pready tied high
//
// Add: abs difference registered at acceptance, then busy through the square, sum and
// insert states; in the insert cycle every cell compares and shifts in parallel.
// Pop and clear: busy stays low; a pop result appears the next cycle.
// Reset is synchronous and active high; it empties the chain and sets the null type.
module transparent_item_depth_sorter #(
   parameter int CAPACITY = tids_pkg::CAPACITY_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_kind,
   input  logic [tids_pkg::TYPE_W-1:0]            req_item_type,
   input  logic [tids_pkg::HANDLE_W-1:0]          req_item_handle,
   input  logic [tids_pkg::HANDLE_W-1:0]          req_owner_handle,
   input  logic signed [tids_pkg::COORD_W-1:0]    req_pos_x,
   input  logic signed [tids_pkg::COORD_W-1:0]    req_pos_y,
   input  logic signed [tids_pkg::COORD_W-1:0]    req_pos_z,
   output logic                                   rsp_valid,
   output logic [tids_pkg::TYPE_W-1:0]            rsp_out_type,
   output logic [tids_pkg::HANDLE_W-1:0]          rsp_out_handle,
   output logic [tids_pkg::HANDLE_W-1:0]          rsp_out_owner,
   output logic                                   rsp_change_state,
   output logic [tids_pkg::TYPE_W-1:0]            rsp_previous_type,
   output logic                                   rsp_close_after,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [3:0]                             paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   localparam int FILL_W = $clog2(CAPACITY + 1);

   tids_pkg::state_type state_ff, state_in;

   logic signed [tids_pkg::COORD_W-1:0] view_x_ff, view_y_ff, view_z_ff;
   logic [FILL_W-1:0]                   fill_ff;
   logic [tids_pkg::TYPE_W-1:0]         last_ff;
   logic [tids_pkg::TYPE_W-1:0]         add_type_ff;
   logic [tids_pkg::HANDLE_W-1:0]       add_handle_ff;
   logic [tids_pkg::HANDLE_W-1:0]       add_owner_ff;

   logic                                rsp_valid_ff;
   logic [tids_pkg::TYPE_W-1:0]         rsp_type_ff;
   logic [tids_pkg::HANDLE_W-1:0]       rsp_handle_ff;
   logic [tids_pkg::HANDLE_W-1:0]       rsp_owner_ff;
   logic                                rsp_change_ff;
   logic [tids_pkg::TYPE_W-1:0]         rsp_prev_ff;
   logic                                rsp_close_ff;

   logic                                accept;
   logic                                key_load;
   logic                                do_ins;
   logic                                do_pop;
   logic                                full;
   logic                                csr_wr;
   logic [tids_pkg::KEY_W-1:0]          new_key;
   tids_pkg::entry_type                 new_item;
   tids_pkg::cell_ctl_type              cell_ctl;
   tids_pkg::entry_type                 cell_q [CAPACITY];
   logic                                cell_after [CAPACITY];

   // Control FSM
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tids_pkg::ST_IDLE: begin
            if (accept && req_kind == tids_pkg::KIND_ADD) begin
               state_in = tids_pkg::ST_MUL;
            end
         end
         tids_pkg::ST_MUL: state_in = tids_pkg::ST_SUM;
         tids_pkg::ST_SUM: state_in = tids_pkg::ST_INS;
         tids_pkg::ST_INS: state_in = tids_pkg::ST_IDLE;
         default:          state_in = tids_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy     = 1'b1;
      key_load = 1'b0;
      do_ins   = 1'b0;
      case (state_ff)
         tids_pkg::ST_IDLE: begin
            busy     = 1'b0;
            key_load = start;
         end
         tids_pkg::ST_MUL: busy = 1'b1;
         tids_pkg::ST_SUM: busy = 1'b1;
         tids_pkg::ST_INS: do_ins = !full;
         default:          busy = 1'b1;
      endcase
   end

   assign accept = start && !busy;
   assign full   = (fill_ff == FILL_W'(CAPACITY));
   assign do_pop = accept && (req_kind == tids_pkg::KIND_POP) && (fill_ff != '0);
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tids_pkg::ST_IDLE;
         fill_ff      <= '0;
         last_ff      <= tids_pkg::NULL_TYPE;
         rsp_valid_ff <= 1'b0;
         view_x_ff    <= '0;
         view_y_ff    <= '0;
         view_z_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= do_pop;
         if (do_ins) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop) begin
            fill_ff <= fill_ff - 1'b1;
            last_ff <= (fill_ff == FILL_W'(1)) ? tids_pkg::NULL_TYPE : cell_q[0].item_type;
         end else if (accept && req_kind == tids_pkg::KIND_CLEAR) begin
            fill_ff <= '0;
            last_ff <= tids_pkg::NULL_TYPE;
         end
         if (csr_wr) begin
            case (paddr[3:2])
               tids_pkg::REG_VIEW_X: view_x_ff <= pwdata[tids_pkg::COORD_W-1:0];
               tids_pkg::REG_VIEW_Y: view_y_ff <= pwdata[tids_pkg::COORD_W-1:0];
               tids_pkg::REG_VIEW_Z: view_z_ff <= pwdata[tids_pkg::COORD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         add_type_ff   <= req_item_type;
         add_handle_ff <= req_item_handle;
         add_owner_ff  <= req_owner_handle;
      end
      if (do_pop) begin
         rsp_type_ff   <= cell_q[0].item_type;
         rsp_handle_ff <= cell_q[0].handle;
         rsp_owner_ff  <= cell_q[0].owner;
         rsp_change_ff <= (cell_q[0].item_type != last_ff);
         rsp_prev_ff   <= last_ff;
         rsp_close_ff  <= (fill_ff == FILL_W'(1));
      end
   end

   always_comb begin
      case (paddr[3:2])
         tids_pkg::REG_VIEW_X: prdata = 32'(view_x_ff);
         tids_pkg::REG_VIEW_Y: prdata = 32'(view_y_ff);
         tids_pkg::REG_VIEW_Z: prdata = 32'(view_z_ff);
         default:              prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   tids_key u_key (
      .clock  (clock),
      .load   (key_load),
      .view_x (view_x_ff),
      .view_y (view_y_ff),
      .view_z (view_z_ff),
      .pos_x  (req_pos_x),
      .pos_y  (req_pos_y),
      .pos_z  (req_pos_z),
      .key    (new_key)
   );

   assign new_item.key       = new_key;
   assign new_item.item_type = add_type_ff;
   assign new_item.handle    = add_handle_ff;
   assign new_item.owner     = add_owner_ff;
   assign cell_ctl.ins       = do_ins;
   assign cell_ctl.pop       = do_pop;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      tids_pkg::entry_type left_item;
      tids_pkg::entry_type right_item;
      logic                left_after;
      logic                occupied;

      if (i == 0) begin : g_head
         assign left_item  = new_item;
         assign left_after = 1'b1;
      end else begin : g_mid
         assign left_item  = cell_q[i-1];
         assign left_after = cell_after[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_item = cell_q[i];
      end else begin : g_body
         assign right_item = cell_q[i+1];
      end

      assign occupied = (FILL_W'(i) < fill_ff);

      tids_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .new_item   (new_item),
         .left_item  (left_item),
         .right_item (right_item),
         .occupied   (occupied),
         .left_after (left_after),
         .item       (cell_q[i]),
         .after      (cell_after[i])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_type      = rsp_type_ff;
   assign rsp_out_handle    = rsp_handle_ff;
   assign rsp_out_owner     = rsp_owner_ff;
   assign rsp_change_state  = rsp_change_ff;
   assign rsp_previous_type = rsp_prev_ff;
   assign rsp_close_after   = rsp_close_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill count above capacity");

   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && req_kind == tids_pkg::KIND_POP))
      else $error("result without a pop");

   a_close_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_close_after |-> fill_ff == '0 && last_ff == tids_pkg::NULL_TYPE)
      else $error("last pop did not empty the store");

   a_ins_returns: assert property (@(posedge clock) disable iff (reset)
      state_ff == tids_pkg::ST_INS |=> state_ff == tids_pkg::ST_IDLE)
      else $error("insert cycle not followed by idle");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      fill_ff >= FILL_W'(2) |-> cell_q[0].key >= cell_q[1].key)
      else $error("head of chain out of order");
`endif

endmodule

### sv/tids_key.sv
// Squared-distance key pipeline: abs difference, square, sum (three register stages).
// Depends on tids_pkg.
module tids_key (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [tids_pkg::COORD_W-1:0] view_x,
   input  logic signed [tids_pkg::COORD_W-1:0] view_y,
   input  logic signed [tids_pkg::COORD_W-1:0] view_z,
   input  logic signed [tids_pkg::COORD_W-1:0] pos_x,
   input  logic signed [tids_pkg::COORD_W-1:0] pos_y,
   input  logic signed [tids_pkg::COORD_W-1:0] pos_z,
   output logic [tids_pkg::KEY_W-1:0]           key
);

   logic signed [tids_pkg::DIFF_W-1:0] dx, dy, dz;
   logic [tids_pkg::DIFF_W-1:0] ax_ff, ay_ff, az_ff;
   logic [tids_pkg::DIFF_W-1:0] ax_in, ay_in, az_in;
   logic [tids_pkg::SQ_W-1:0]   sx_ff, sy_ff, sz_ff;
   logic [tids_pkg::KEY_W-1:0]  sum_ff;

   assign dx = tids_pkg::DIFF_W'(pos_x) - tids_pkg::DIFF_W'(view_x);
   assign dy = tids_pkg::DIFF_W'(pos_y) - tids_pkg::DIFF_W'(view_y);
   assign dz = tids_pkg::DIFF_W'(pos_z) - tids_pkg::DIFF_W'(view_z);

   assign ax_in = dx[tids_pkg::DIFF_W-1] ? tids_pkg::DIFF_W'(-dx) : tids_pkg::DIFF_W'(dx);
   assign ay_in = dy[tids_pkg::DIFF_W-1] ? tids_pkg::DIFF_W'(-dy) : tids_pkg::DIFF_W'(dy);
   assign az_in = dz[tids_pkg::DIFF_W-1] ? tids_pkg::DIFF_W'(-dz) : tids_pkg::DIFF_W'(dz);

   always_ff @(posedge clock) begin
      if (load) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         az_ff <= az_in;
      end
      sx_ff  <= ax_ff * ax_ff;
      sy_ff  <= ay_ff * ay_ff;
      sz_ff  <= az_ff * az_ff;
      sum_ff <= tids_pkg::KEY_W'(sx_ff) + tids_pkg::KEY_W'(sy_ff) + tids_pkg::KEY_W'(sz_ff);
   end

   assign key = sum_ff;

endmodule

### sv/tids_cell.sv
// One slot of the sorted chain: holds an entry, compares against the new key,
// shifts toward the tail on insert and toward the head on pop. Depends on tids_pkg.
module tids_cell (
   input  logic                   clock,
   input  tids_pkg::cell_ctl_type ctl,
   input  tids_pkg::entry_type    new_item,
   input  tids_pkg::entry_type    left_item,
   input  tids_pkg::entry_type    right_item,
   input  logic                   occupied,
   input  logic                   left_after,
   output tids_pkg::entry_type    item,
   output logic                   after
);

   tids_pkg::entry_type item_ff;
   tids_pkg::entry_type item_in;

   assign after = occupied && (item_ff.key >= new_item.key);

   always_comb begin
      item_in = item_ff;
      if (ctl.pop) begin
         item_in = right_item;
      end else if (ctl.ins && !after) begin
         item_in = left_after ? new_item : left_item;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item = item_ff;

endmodule
